[hdl/bfa_pkg.sv]
// Shared types and codes for the bitmap first-fit allocator.
// Used by bfa_cell and bitmap_first_fit_allocator; depends on nothing.
`default_nettype none

package bfa_pkg;

  localparam int WORD_W = 32;
  localparam int BIT_POS_W = 5;
  localparam int ENTRY_COUNT_W = 11;
  localparam logic [ENTRY_COUNT_W-1:0] ENTRY_COUNT_RESET = 11'd1024;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_FULL      = 2'd1,
    ST_LOADED    = 2'd2
  } bfa_status_t;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_ALLOC = 1'b1
  } bfa_cmd_t;

  typedef enum logic {
    REG_ENTRY_COUNT = 1'b0,
    REG_SLOT_OFFSET = 1'b1
  } bfa_reg_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } bfa_state_t;

  // Search token that walks the row of bitmap cells.
  typedef struct packed {
    logic active;
    logic found;
  } bfa_probe_t;

endpackage

`default_nettype wire

[hdl/bfa_cell.sv]
// One bitmap word of the allocator and its stage of the search chain.
// Depends on bfa_pkg for the word width and the search token type.
`default_nettype none

module bfa_cell #(
  parameter int IDX  = 0,
  parameter int IDXW = 10,
  parameter int LIMW = 11
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [LIMW-1:0]               limit,
  input  wire logic                          load_en,
  input  wire logic [bfa_pkg::WORD_W-1:0]    load_data,
  input  wire bfa_pkg::bfa_probe_t           probe_in,
  input  wire logic [IDXW-1:0]               idx_in,
  output bfa_pkg::bfa_probe_t                probe_out,
  output logic [IDXW-1:0]                    idx_out
);

  localparam int BASE = IDX * bfa_pkg::WORD_W;
  localparam logic [LIMW-6:0] WORD_NUM = (LIMW-5)'(IDX);

  logic [bfa_pkg::WORD_W-1:0]   word;
  logic [bfa_pkg::WORD_W-1:0]   in_range;
  logic [bfa_pkg::WORD_W-1:0]   avail;
  logic [bfa_pkg::WORD_W-1:0]   lowest;
  logic [bfa_pkg::BIT_POS_W-1:0] pos;
  logic                          hit;
  logic                          claim;

  // Only bits whose entry index lies below the limit may be handed out.
  always_comb begin
    if (limit[LIMW-1:5] > WORD_NUM) begin
      in_range = '1;
    end else if (limit[LIMW-1:5] == WORD_NUM) begin
      in_range = (32'd1 << limit[4:0]) - 32'd1;
    end else begin
      in_range = '0;
    end
  end

  assign avail  = ~word & in_range;
  assign lowest = avail & (~avail + 32'd1);
  assign hit    = |avail;
  assign claim  = probe_in.active && !probe_in.found && hit;

  always_comb begin
    pos = '0;
    for (int b = 0; b < bfa_pkg::WORD_W; b++) begin
      pos = pos | (lowest[b] ? bfa_pkg::BIT_POS_W'(b) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word <= '0;
    end else if (load_en) begin
      word <= load_data;
    end else if (claim) begin
      word <= word | lowest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
    end else begin
      probe_out.active <= probe_in.active;
      probe_out.found  <= probe_in.found || claim;
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      idx_out <= IDXW'(BASE) | IDXW'(pos);
    end else begin
      idx_out <= idx_in;
    end
  end

endmodule

`default_nettype wire

[hdl/bitmap_first_fit_allocator.sv]
// Top level of the bitmap first-fit allocator: configuration registers,
// command sequencer and the row of bfa_cell words. Depends on bfa_pkg and bfa_cell.
`default_nettype none

// A load command writes one bitmap word straight into its cell and its result
// (status loaded) is offered in the cycle after the transfer. An allocate command
// sends a search token down a row of ENTRIES/32 cells, one cell per clock: the
// token is registered at launch, passes one register in each bitmap word, and the
// result is registered at the end. The cell that finds the lowest free bit below
// the limit sets it as the token passes. The input stalls while a search runs and
// while a result is waiting to be taken. ENTRIES must be a multiple of 32; reset
// clears every bitmap word at once.

module bitmap_first_fit_allocator #(
  parameter int ENTRIES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        command,
  input  wire logic [4:0]  word_index,
  input  wire logic [31:0] word_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [31:0]      slot
);

  localparam int WORDS = ENTRIES / 32;
  localparam int IDXW  = $clog2(ENTRIES);
  localparam int LIMW  = $clog2(ENTRIES + 1);
  localparam int CW    = (LIMW > bfa_pkg::ENTRY_COUNT_W) ? LIMW : bfa_pkg::ENTRY_COUNT_W;

  logic [bfa_pkg::ENTRY_COUNT_W-1:0] entry_count;
  logic [31:0]                       slot_offset;
  logic [CW-1:0]                     count_ext;
  logic [LIMW-1:0]                   limit;

  bfa_pkg::bfa_state_t state;
  bfa_pkg::bfa_state_t state_next;
  bfa_pkg::bfa_probe_t launch;
  bfa_pkg::bfa_probe_t probe_chain [WORDS+1];
  logic [IDXW-1:0]     idx_chain   [WORDS+1];
  bfa_pkg::bfa_probe_t tail;

  logic in_fire;
  logic out_fire;
  logic start_scan;
  logic do_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= bfa_pkg::ENTRY_COUNT_RESET;
      slot_offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bfa_pkg::bfa_reg_t'(cfg_index))
        bfa_pkg::REG_ENTRY_COUNT: entry_count <= cfg_data[bfa_pkg::ENTRY_COUNT_W-1:0];
        bfa_pkg::REG_SLOT_OFFSET: slot_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // The usable range is the configured count, capped at the store size.
  assign count_ext = CW'(entry_count);
  assign limit = (count_ext > CW'(ENTRIES)) ? LIMW'(ENTRIES) : LIMW'(count_ext);

  assign in_stall = (state != bfa_pkg::S_IDLE) || (out_valid && out_stall);
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign do_load  = in_fire && (bfa_pkg::bfa_cmd_t'(command) == bfa_pkg::CMD_LOAD);
  assign tail     = probe_chain[WORDS];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    start_scan = 1'b0;
    unique case (state)
      bfa_pkg::S_IDLE: begin
        if (in_fire && bfa_pkg::bfa_cmd_t'(command) == bfa_pkg::CMD_ALLOC) begin
          start_scan = 1'b1;
          state_next = bfa_pkg::S_SCAN;
        end
      end
      bfa_pkg::S_SCAN: begin
        if (tail.active) begin
          state_next = bfa_pkg::S_IDLE;
        end
      end
      default: state_next = bfa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      launch <= '0;
    end else begin
      launch.active <= start_scan;
      launch.found  <= 1'b0;
    end
  end

  assign probe_chain[0] = launch;
  assign idx_chain[0]   = '0;

  for (genvar k = 0; k < WORDS; k++) begin : g_cell
    logic load_en;
    assign load_en = do_load && (k < 32) && (word_index == 5'(k));

    bfa_cell #(
      .IDX  (k),
      .IDXW (IDXW),
      .LIMW (LIMW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .limit     (limit),
      .load_en   (load_en),
      .load_data (word_data),
      .probe_in  (probe_chain[k]),
      .idx_in    (idx_chain[k]),
      .probe_out (probe_chain[k+1]),
      .idx_out   (idx_chain[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_load || (state == bfa_pkg::S_SCAN && tail.active)) begin
      out_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      status <= bfa_pkg::ST_LOADED;
      slot   <= '0;
    end else if (state == bfa_pkg::S_SCAN && tail.active) begin
      if (tail.found) begin
        status <= bfa_pkg::ST_ALLOCATED;
        slot   <= 32'(idx_chain[WORDS]) + slot_offset;
      end else begin
        status <= bfa_pkg::ST_FULL;
        slot   <= '0;
      end
    end
  end

  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    tail.active |-> state == bfa_pkg::S_SCAN)
    else $error("search token left the chain outside a scan");

  a_no_result_during_scan: assert property (@(posedge clk) disable iff (rst)
    state == bfa_pkg::S_SCAN |-> !out_valid)
    else $error("result pending while a search runs");

  a_slot_zero_unless_alloc: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != bfa_pkg::ST_ALLOCATED) |-> slot == '0)
    else $error("nonzero slot on a result that allocated nothing");

  a_load_result_next: assert property (@(posedge clk) disable iff (rst)
    do_load |=> out_valid && status == bfa_pkg::ST_LOADED)
    else $error("load transfer did not produce a loaded result");

endmodule

`default_nettype wire

[tb/sv/tb_bitmap_first_fit_allocator.sv]
// Self-checking testbench for bitmap_first_fit_allocator: directed cases, then random
// phases of bitmap loads and first-fit allocations, with a bitmap predictor kept in step.
// Depends on bfa_pkg and the bitmap_first_fit_allocator RTL.
`default_nettype none

module tb_bitmap_first_fit_allocator;

  localparam int ENTRIES = 1024;
  localparam int MAP_WORDS = ENTRIES / 32;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = ENTRIES / 32 + 8;

  typedef struct {
    bfa_pkg::bfa_status_t status;
    logic [31:0]          slot;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = 1'b0;
  logic [4:0]  word_index = '0;
  logic [31:0] word_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [31:0] slot;

  // Predictor state: a private copy of the usage bitmap and both registers.
  logic [31:0]  usage_map [MAP_WORDS];
  logic [10:0]  limit_reg;
  logic [31:0]  offset_reg;
  answer_t      answer_q[$];
  answer_t      head;
  int unsigned  errors = 0;
  int unsigned  cycle_count = 0;
  bit           idle_en = 1'b0;
  int unsigned  stall_left = 0;

  bitmap_first_fit_allocator #(.ENTRIES(ENTRIES)) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .word_index(word_index),
    .word_data(word_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .slot(slot)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("bitmap_first_fit_allocator test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("ERROR cycle %0d: %s", cycle_count, what);
    errors++;
  endtask

  // Applies one command to the predicted bitmap and returns the expected answer.
  function automatic answer_t allocate_or_load(bfa_pkg::bfa_cmd_t cmd, logic [4:0] widx,
                                               logic [31:0] data);
    answer_t     a;
    int unsigned lim;
    a.status = bfa_pkg::ST_FULL;
    a.slot = '0;
    if (cmd == bfa_pkg::CMD_LOAD) begin
      usage_map[widx] = data;
      a.status = bfa_pkg::ST_LOADED;
    end else begin
      lim = (limit_reg > ENTRIES) ? ENTRIES : limit_reg;
      for (int i = 0; i < lim; i++) begin
        if (!usage_map[i / 32][i % 32]) begin
          usage_map[i / 32][i % 32] = 1'b1;
          a.status = bfa_pkg::ST_ALLOCATED;
          a.slot = 32'(i) + offset_reg;
          break;
        end
      end
    end
    return a;
  endfunction

  // Result side: random stall bursts while idling is enabled.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (answer_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d slot=%h", status, slot));
      end else begin
        head = answer_q.pop_front();
        if (status !== head.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, head.status));
        if (slot !== head.slot)
          report_mismatch($sformatf("slot %h, expected %h", slot, head.slot));
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_command(input bfa_pkg::bfa_cmd_t cmd, input logic [4:0] widx,
                              input logic [31:0] data);
    int unsigned gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 15);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    command = cmd;
    word_index = widx;
    word_data = data;
    do @(posedge clk); while (in_stall);
    answer_q.push_back(allocate_or_load(cmd, widx, data));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (answer_q.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input bfa_pkg::bfa_reg_t idx, input logic [31:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == bfa_pkg::REG_ENTRY_COUNT) limit_reg = value[10:0];
    else offset_reg = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Reset values: full range, no offset, every slot free.
  task automatic test_alloc_after_reset();
    repeat (3) send_command(bfa_pkg::CMD_ALLOC, '0, '0);
  endtask

  task automatic test_word_loads();
    send_command(bfa_pkg::CMD_LOAD, 5'd0, 32'hFFFF_FFFF);
    send_command(bfa_pkg::CMD_ALLOC, 5'd31, 32'hFFFF_FFFF);
    send_command(bfa_pkg::CMD_LOAD, 5'd1, 32'h7FFF_FFFF);
    send_command(bfa_pkg::CMD_ALLOC, '0, '0);
    send_command(bfa_pkg::CMD_LOAD, 5'd31, 32'hFFFF_FFFF);
    send_command(bfa_pkg::CMD_LOAD, 5'd0, 32'h0000_0000);
    send_command(bfa_pkg::CMD_ALLOC, '0, '0);
    wait_idle();
  endtask

  // Zero entries, bits past the limit, and a count above capacity.
  task automatic test_entry_limits();
    write_reg(bfa_pkg::REG_ENTRY_COUNT, 32'd0);
    send_command(bfa_pkg::CMD_ALLOC, '0, '0);
    wait_idle();
    write_reg(bfa_pkg::REG_ENTRY_COUNT, 32'd33);
    send_command(bfa_pkg::CMD_LOAD, 5'd0, 32'hFFFF_FFFF);
    send_command(bfa_pkg::CMD_LOAD, 5'd1, 32'h0000_0001);
    send_command(bfa_pkg::CMD_ALLOC, '0, '0);
    wait_idle();
    write_reg(bfa_pkg::REG_ENTRY_COUNT, 32'd34);
    send_command(bfa_pkg::CMD_ALLOC, '0, '0);
    send_command(bfa_pkg::CMD_ALLOC, '0, '0);
    wait_idle();
    write_reg(bfa_pkg::REG_ENTRY_COUNT, 32'hFFFF_F7FF);
    send_command(bfa_pkg::CMD_ALLOC, '0, '0);
    wait_idle();
  endtask

  task automatic test_offset_wrap();
    write_reg(bfa_pkg::REG_SLOT_OFFSET, 32'hFFFF_FFFF);
    send_command(bfa_pkg::CMD_ALLOC, '0, '0);
    send_command(bfa_pkg::CMD_ALLOC, '0, '0);
    wait_idle();
    write_reg(bfa_pkg::REG_SLOT_OFFSET, 32'hFFFF_FFE0);
    send_command(bfa_pkg::CMD_ALLOC, '0, '0);
    send_command(bfa_pkg::CMD_ALLOC, '0, '0);
    wait_idle();
  endtask

  // Loads every word as used except possibly one bit, then allocates past it.
  task automatic fill_sequence(inout int unsigned sent);
    int unsigned hole_word;
    int unsigned hole_bit;
    logic [31:0] data;
    hole_word = $urandom_range(0, MAP_WORDS);
    hole_bit = $urandom_range(0, 31);
    for (int w = 0; w < MAP_WORDS; w++) begin
      data = 32'hFFFF_FFFF;
      if (w == hole_word) data[hole_bit] = 1'b0;
      send_command(bfa_pkg::CMD_LOAD, 5'(w), data);
    end
    repeat (3) send_command(bfa_pkg::CMD_ALLOC, 5'($urandom), $urandom);
    sent += MAP_WORDS + 3;
  endtask

  task automatic random_phase(input int unsigned n, input logic [31:0] count,
                              input logic [31:0] offset, input bit idling);
    int unsigned sent;
    int unsigned pick;
    logic [31:0] data;
    write_reg(bfa_pkg::REG_ENTRY_COUNT, count);
    write_reg(bfa_pkg::REG_SLOT_OFFSET, offset);
    idle_en = idling;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        fill_sequence(sent);
      end else if (pick < 55) begin
        send_command(bfa_pkg::CMD_ALLOC, 5'($urandom), $urandom);
        sent++;
      end else begin
        pick = $urandom_range(0, 99);
        data = $urandom;
        if (pick < 45) data = 32'hFFFF_FFFF;
        else if (pick < 65) data = ~(32'd1 << $urandom_range(0, 31));
        else if (pick < 80) data = '0;
        send_command(bfa_pkg::CMD_LOAD, 5'($urandom), data);
        sent++;
      end
    end
    wait_idle();
  endtask

  initial begin
    limit_reg = bfa_pkg::ENTRY_COUNT_RESET;
    offset_reg = '0;
    for (int w = 0; w < MAP_WORDS; w++) usage_map[w] = '0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    test_alloc_after_reset();
    test_word_loads();
    test_entry_limits();
    test_offset_wrap();

    random_phase(115, 32'd1024, 32'd0, 1'b1);
    random_phase(115, 32'd0, $urandom, 1'b1);
    random_phase(115, 32'd1, 32'd1, 1'b1);
    random_phase(115, 32'd32, 32'hFFFF_FFF0, 1'b1);
    random_phase(115, 32'd33, $urandom, 1'b0);
    random_phase(115, 32'd2047, 32'hFFFF_FFFF, 1'b1);
    random_phase(115, 32'd1000, $urandom, 1'b1);
    random_phase(115, $urandom_range(0, 2047), $urandom, 1'b1);
    random_phase(115, 32'd1024, 32'd0, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (answer_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", answer_q.size()));
    if (errors == 0) begin
      $display("bitmap_first_fit_allocator test passed");
    end else begin
      $display("bitmap_first_fit_allocator test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
